// ===== rtl/nect_pkg.sv =====
package nect_pkg;

    // Default sizes
    localparam int SLOTS_DEF      = 32;
    localparam int NAME_BYTES_DEF = 32;
    localparam int ROOT_BITS_DEF  = 32;

    // Request codes
    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_LOOKUP = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;

    // Status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_DUPLICATE = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    // Request word
    typedef struct packed {
        logic [1:0]  op;
        logic [63:0] key_word0;
        logic [63:0] key_word1;
        logic [63:0] key_word2;
        logic [63:0] key_word3;
        logic [7:0]  entry_kind;
        logic [31:0] root_page;
    } t_req;

    // Result word
    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  found_kind;
        logic [31:0] found_root;
        logic [5:0]  active_count;
    } t_rsp;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_COMPARE,
        S_UPDATE
    } t_state;

    // Strobes from the sequencer to every cell
    typedef struct packed {
        logic compare;
        logic write;
        logic clear;
    } t_ctl;

    // Priority and readout chain between neighboring cells
    typedef struct packed {
        logic        hit_seen;
        logic        free_seen;
        logic [7:0]  kind;
        logic [63:0] root;
    } t_link;

endpackage

// ===== rtl/nect_cell.sv =====
module nect_cell #(
    parameter int KEY_BITS  = 8 * nect_pkg::NAME_BYTES_DEF,
    parameter int ROOT_BITS = nect_pkg::ROOT_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  nect_pkg::t_ctl       i_ctl,
    input  logic [KEY_BITS-1:0]  i_key,
    input  logic [7:0]           i_kind,
    input  logic [ROOT_BITS-1:0] i_root,
    input  nect_pkg::t_link      i_link,
    output nect_pkg::t_link      o_link
);

    logic                 r_valid;
    logic                 r_match;
    logic [KEY_BITS-1:0]  r_key;
    logic [7:0]           r_kind;
    logic [ROOT_BITS-1:0] r_root;

    logic sel_hit;
    logic sel_free;

    // First match and first free slot: no cell below has claimed it
    assign sel_hit  = r_match && !i_link.hit_seen;
    assign sel_free = !r_valid && !i_link.free_seen;

    // Pass priority and selected entry data to the next cell
    always_comb begin
        o_link.hit_seen  = i_link.hit_seen | r_match;
        o_link.free_seen = i_link.free_seen | !r_valid;
        o_link.kind      = i_link.kind | (sel_hit ? r_kind : 8'd0);
        o_link.root      = i_link.root | (sel_hit ? 64'(r_root) : 64'd0);
    end

    // Valid bit and match flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_match <= 1'b0;
        end else begin
            if (i_ctl.compare) begin
                r_match <= r_valid && (r_key == i_key);
            end
            if (i_ctl.write && sel_free) begin
                r_valid <= 1'b1;
            end else if (i_ctl.clear && sel_hit) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Entry payload
    always_ff @(posedge i_clk) begin
        if (i_ctl.write && sel_free) begin
            r_key  <= i_key;
            r_kind <= i_kind;
            r_root <= i_root;
        end
    end

endmodule

// ===== rtl/named_entry_catalog_table_core.sv =====
// Catalog of named slots, searched by content.
// Request channel: drive i_req and raise start; the word is taken at a rising
// edge with start high and busy low. Requests are add, lookup and remove.
// Result channel: o_done is high for exactly one cycle with o_rsp holding the
// status, the found type code and root page (lookup hit only, else zero) and
// the active entry count after the request. The receiver cannot stall.
// The accept edge enters S_COMPARE, the edge leaving S_COMPARE registers
// the per-slot key compares, and the edge leaving S_UPDATE resolves priority
// along the slot chain and commits; o_done is high in the cycle after that,
// and busy is already low there.
// Each cell holds one slot; first-match and first-free priority and the
// selected entry data ripple from cell 0 upward.
// Reset (synchronous, active low) clears all valid bits and the count at a
// rising edge of i_clk; the table is usable once i_rst_n is high again.
module named_entry_catalog_table_core #(
    parameter int SLOTS      = nect_pkg::SLOTS_DEF,
    parameter int NAME_BYTES = nect_pkg::NAME_BYTES_DEF,
    parameter int ROOT_BITS  = nect_pkg::ROOT_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  nect_pkg::t_req i_req,
    output logic           o_done,
    output nect_pkg::t_rsp o_rsp
);

    localparam int KEY_BITS = 8 * NAME_BYTES;
    localparam int CNT_W    = $clog2(SLOTS + 1);

    nect_pkg::t_state r_state, n_state;
    logic [1:0]           r_op;
    logic [KEY_BITS-1:0]  r_key;
    logic [7:0]           r_kind;
    logic [ROOT_BITS-1:0] r_root;
    logic [CNT_W-1:0]     r_count, n_count;
    nect_pkg::t_rsp       r_rsp, n_rsp;
    logic                 r_done, n_done;

    nect_pkg::t_ctl  ctl;
    nect_pkg::t_link links [SLOTS+1];
    nect_pkg::t_link tail;
    logic            accept;
    logic [255:0]    full_key;

    assign accept   = start && !busy;
    assign full_key = {i_req.key_word3, i_req.key_word2, i_req.key_word1, i_req.key_word0};
    assign tail     = links[SLOTS];
    assign links[0] = '0;

    // Slot chain
    for (genvar g = 0; g < SLOTS; g++) begin : g_cell
        nect_cell #(
            .KEY_BITS  (KEY_BITS),
            .ROOT_BITS (ROOT_BITS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (ctl),
            .i_key   (r_key),
            .i_kind  (r_kind),
            .i_root  (r_root),
            .i_link  (links[g]),
            .o_link  (links[g+1])
        );
    end

    // Request capture; name bytes beyond NAME_BYTES are dropped here
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op   <= i_req.op;
            r_key  <= full_key[KEY_BITS-1:0];
            r_kind <= i_req.entry_kind;
            r_root <= ROOT_BITS'(64'(i_req.root_page));
        end
    end

    // State, count and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= nect_pkg::S_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rsp <= n_rsp;
    end

    // Sequencer and result decode
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_done      = 1'b0;
        n_rsp       = r_rsp;
        ctl         = '0;
        busy        = (r_state != nect_pkg::S_IDLE);
        unique case (r_state)
            nect_pkg::S_IDLE: begin
                if (start) begin
                    n_state = nect_pkg::S_COMPARE;
                end
            end
            nect_pkg::S_COMPARE: begin
                ctl.compare = 1'b1;
                n_state     = nect_pkg::S_UPDATE;
            end
            nect_pkg::S_UPDATE: begin
                n_state            = nect_pkg::S_IDLE;
                n_done             = 1'b1;
                n_rsp.status       = nect_pkg::ST_OK;
                n_rsp.found_kind   = 8'd0;
                n_rsp.found_root   = 32'd0;
                unique case (r_op)
                    nect_pkg::OP_ADD: begin
                        if (tail.hit_seen) begin
                            n_rsp.status = nect_pkg::ST_DUPLICATE;
                        end else if (!tail.free_seen) begin
                            n_rsp.status = nect_pkg::ST_FULL;
                        end else begin
                            ctl.write = 1'b1;
                            n_count   = r_count + CNT_W'(1);
                        end
                    end
                    nect_pkg::OP_LOOKUP: begin
                        if (tail.hit_seen) begin
                            n_rsp.found_kind = tail.kind;
                            n_rsp.found_root = tail.root[31:0];
                        end else begin
                            n_rsp.status = nect_pkg::ST_NOT_FOUND;
                        end
                    end
                    nect_pkg::OP_REMOVE: begin
                        if (tail.hit_seen) begin
                            ctl.clear = 1'b1;
                            if (r_count != '0) begin
                                n_count = r_count - CNT_W'(1);
                            end
                        end else begin
                            n_rsp.status = nect_pkg::ST_NOT_FOUND;
                        end
                    end
                    default: begin
                        n_rsp.status = nect_pkg::ST_NOT_FOUND;
                    end
                endcase
                n_rsp.active_count = 6'(n_count);
            end
            default: begin
                n_state = nect_pkg::S_IDLE;
            end
        endcase
    end

    assign o_done = r_done;
    assign o_rsp  = r_rsp;

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

    // Request code the block does not define
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam int TABLE_SLOTS = nect_pkg::SLOTS_DEF;
    localparam int POOL_NAMES  = 36;
    localparam int PHASE_ITEMS = 250;
    localparam int QUIET_LIMIT = 2000;

    // Some fixed names for the directed part
    localparam logic [255:0] NAME_ZERO  = '0;
    localparam logic [255:0] NAME_ONES  = '1;
    localparam logic [255:0] NAME_CAT   = 256'h0067_6f6c_6174_6163;
    localparam logic [255:0] NAME_CAT_X = NAME_CAT ^ (256'h1 << 255);
    localparam logic [255:0] NAME_PFX   = {224'b0, NAME_CAT[31:0]};

    typedef struct {
        nect_pkg::t_req req;
        bit             typed;
        nect_pkg::t_rsp want;
    } t_dir_row;

    logic           i_clk;
    logic           i_rst_n;
    logic           start;
    logic           busy;
    nect_pkg::t_req i_req;
    logic           o_done;
    nect_pkg::t_rsp o_rsp;

    // Typed expectation riding along with the current request word
    bit             use_typed;
    nect_pkg::t_rsp typed_rsp;

    // Shadow copy of the catalog
    bit          tbl_valid [TABLE_SLOTS];
    logic [63:0] tbl_key   [TABLE_SLOTS][4];
    logic [7:0]  tbl_kind  [TABLE_SLOTS];
    logic [31:0] tbl_root  [TABLE_SLOTS];
    int          tbl_total;

    nect_pkg::t_rsp pending_rsp [$];
    t_dir_row       dir_rows [$];
    logic [255:0]   name_pool [POOL_NAMES];
    int             err_count;

    named_entry_catalog_table_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_req   (i_req),
        .o_done  (o_done),
        .o_rsp   (o_rsp)
    );

    // 10 ns clock
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Predict the answer to one request and update the shadow catalog
    function automatic nect_pkg::t_rsp catalog_outcome(nect_pkg::t_req r);
        int             hit;
        int             vacant;
        nect_pkg::t_rsp o;
        hit    = -1;
        vacant = -1;
        o      = '0;
        for (int s = 0; s < TABLE_SLOTS; s++) begin
            if (tbl_valid[s] && hit < 0 && tbl_key[s][0] == r.key_word0 &&
                tbl_key[s][1] == r.key_word1 && tbl_key[s][2] == r.key_word2 &&
                tbl_key[s][3] == r.key_word3)
                hit = s;
            if (!tbl_valid[s] && vacant < 0)
                vacant = s;
        end
        case (r.op)
            nect_pkg::OP_ADD: begin
                if (hit >= 0) begin
                    o.status = nect_pkg::ST_DUPLICATE;
                end else if (vacant < 0) begin
                    o.status = nect_pkg::ST_FULL;
                end else begin
                    tbl_key[vacant][0] = r.key_word0;
                    tbl_key[vacant][1] = r.key_word1;
                    tbl_key[vacant][2] = r.key_word2;
                    tbl_key[vacant][3] = r.key_word3;
                    tbl_kind[vacant]   = r.entry_kind;
                    tbl_root[vacant]   = r.root_page;
                    tbl_valid[vacant]  = 1'b1;
                    tbl_total++;
                end
            end
            nect_pkg::OP_LOOKUP: begin
                if (hit >= 0) begin
                    o.found_kind = tbl_kind[hit];
                    o.found_root = tbl_root[hit];
                end else begin
                    o.status = nect_pkg::ST_NOT_FOUND;
                end
            end
            nect_pkg::OP_REMOVE: begin
                if (hit >= 0) begin
                    tbl_valid[hit] = 1'b0;
                    if (tbl_total > 0)
                        tbl_total--;
                end else begin
                    o.status = nect_pkg::ST_NOT_FOUND;
                end
            end
            default: begin
                o.status = nect_pkg::ST_NOT_FOUND;
            end
        endcase
        o.active_count = tbl_total[5:0];
        return o;
    endfunction

    function automatic nect_pkg::t_req make_req(logic [1:0] op, logic [255:0] name,
                                                logic [7:0] kind, logic [31:0] root);
        nect_pkg::t_req r;
        r.op         = op;
        r.key_word0  = name[63:0];
        r.key_word1  = name[127:64];
        r.key_word2  = name[191:128];
        r.key_word3  = name[255:192];
        r.entry_kind = kind;
        r.root_page  = root;
        return r;
    endfunction

    task automatic log_mismatch(string msg);
        err_count++;
        $display("%0t ns: MISMATCH %s", $time, msg);
    endtask

    task automatic check_field(string field, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            log_mismatch($sformatf("%s: got %0h, expected %0h", field, got, want));
    endtask

    task automatic add_row(logic [1:0] op, logic [255:0] name, logic [7:0] kind,
                           logic [31:0] root, bit typed, logic [1:0] st,
                           logic [7:0] fk, logic [31:0] fr, logic [5:0] cnt);
        t_dir_row row;
        row.req                = make_req(op, name, kind, root);
        row.typed              = typed;
        row.want.status        = st;
        row.want.found_kind    = fk;
        row.want.found_root    = fr;
        row.want.active_count  = cnt;
        dir_rows.push_back(row);
    endtask

    // Present one word and hold it until the block takes it
    task automatic send_word(nect_pkg::t_req r, bit typed, nect_pkg::t_rsp want);
        @(negedge i_clk);
        start     = 1'b1;
        i_req     = r;
        use_typed = typed;
        typed_rsp = want;
        do begin
            @(posedge i_clk);
        end while (busy !== 1'b0);
    endtask

    // Random sender idle cycles
    task automatic sender_gap(int pct);
        while ($urandom_range(99) < pct) begin
            @(negedge i_clk);
            start = 1'b0;
        end
    endtask

    // Hold off until every outstanding answer is back
    task automatic drain_results();
        @(negedge i_clk);
        start = 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge i_clk);
    endtask

    // Mostly names from the pool, some near misses and some noise
    function automatic logic [255:0] pick_name();
        int           roll;
        logic [7:0]   pos;
        logic [255:0] n;
        roll = $urandom_range(99);
        if (roll < 85) begin
            n = name_pool[$urandom_range(POOL_NAMES - 1)];
        end else if (roll < 95) begin
            n      = name_pool[$urandom_range(POOL_NAMES - 1)];
            pos    = 8'($urandom_range(255));
            n[pos] = ~n[pos];
        end else begin
            for (int w = 0; w < 8; w++)
                n[32*w +: 32] = $urandom;
        end
        return n;
    endfunction

    // Result check and request capture
    always @(posedge i_clk) begin : monitor
        nect_pkg::t_rsp want;
        nect_pkg::t_rsp pred;
        if (i_rst_n) begin
            if (o_done === 1'b1) begin
                if (pending_rsp.size() == 0) begin
                    log_mismatch("result word with nothing pending");
                end else begin
                    want = pending_rsp.pop_front();
                    check_field("status", 32'(o_rsp.status), 32'(want.status));
                    check_field("found_kind", 32'(o_rsp.found_kind),
                                32'(want.found_kind));
                    check_field("found_root", o_rsp.found_root, want.found_root);
                    check_field("active_count", 32'(o_rsp.active_count),
                                32'(want.active_count));
                end
            end
            if (start && busy === 1'b0) begin
                pred = catalog_outcome(i_req);
                pending_rsp.push_back(use_typed ? typed_rsp : pred);
            end
        end
    end

    // Give up after a long stretch with no traffic
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || o_done === 1'b1 || (start && busy === 1'b0))
                quiet = 0;
            else
                quiet++;
        end
        $display("named_entry_catalog_table_core test failed");
        $finish;
    end

    initial begin : stimulus
        int             sender_idle [3];
        int             mode_left;
        bit             fill_mode;
        int             roll;
        logic [1:0]     op;
        logic [255:0]   n;
        int             len;
        nect_pkg::t_rsp none;

        sender_idle = '{0, 83, 36};
        none        = '0;
        err_count   = 0;
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_req       = '0;
        use_typed   = 1'b0;
        typed_rsp   = '0;
        for (int s = 0; s < TABLE_SLOTS; s++)
            tbl_valid[s] = 1'b0;
        tbl_total = 0;

        // Zero padded names of random length
        for (int p = 0; p < POOL_NAMES; p++) begin
            len = $urandom_range(1, 32);
            n   = '0;
            for (int b = 0; b < 32; b++)
                if (b < len)
                    n[8*b +: 8] = 8'($urandom_range(1, 255));
            name_pool[p] = n;
        end

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part: empty table, extremes, duplicates, misses
        add_row(nect_pkg::OP_LOOKUP, NAME_CAT, 8'h00, 32'h0, 1'b1,
                nect_pkg::ST_NOT_FOUND, 8'h00, 32'h0, 6'd0);
        add_row(nect_pkg::OP_REMOVE, NAME_CAT, 8'h00, 32'h0, 1'b1,
                nect_pkg::ST_NOT_FOUND, 8'h00, 32'h0, 6'd0);
        add_row(OP_UNUSED, NAME_CAT, 8'hFF, 32'hFFFF_FFFF, 1'b1,
                nect_pkg::ST_NOT_FOUND, 8'h00, 32'h0, 6'd0);
        add_row(nect_pkg::OP_ADD, NAME_ZERO, 8'h00, 32'h0, 1'b1,
                nect_pkg::ST_OK, 8'h00, 32'h0, 6'd1);
        add_row(nect_pkg::OP_ADD, NAME_ONES, 8'hFF, 32'hFFFF_FFFF, 1'b1,
                nect_pkg::ST_OK, 8'h00, 32'h0, 6'd2);
        add_row(nect_pkg::OP_LOOKUP, NAME_ONES, 8'h00, 32'h0, 1'b1,
                nect_pkg::ST_OK, 8'hFF, 32'hFFFF_FFFF, 6'd2);
        add_row(nect_pkg::OP_ADD, NAME_ZERO, 8'h11, 32'h22, 1'b1,
                nect_pkg::ST_DUPLICATE, 8'h00, 32'h0, 6'd2);
        add_row(nect_pkg::OP_LOOKUP, NAME_ZERO, 8'h00, 32'h0, 1'b1,
                nect_pkg::ST_OK, 8'h00, 32'h0, 6'd2);
        add_row(nect_pkg::OP_ADD, NAME_CAT, 8'h5A, 32'h0000_1234, 1'b1,
                nect_pkg::ST_OK, 8'h00, 32'h0, 6'd3);
        add_row(nect_pkg::OP_ADD, NAME_CAT_X, 8'hA5, 32'h8000_0001, 1'b0,
                nect_pkg::ST_OK, 8'h00, 32'h0, 6'd0);
        add_row(nect_pkg::OP_LOOKUP, NAME_CAT, 8'hFF, 32'hFFFF_FFFF, 1'b0,
                nect_pkg::ST_OK, 8'h00, 32'h0, 6'd0);
        add_row(nect_pkg::OP_LOOKUP, NAME_CAT_X, 8'h00, 32'h0, 1'b0,
                nect_pkg::ST_OK, 8'h00, 32'h0, 6'd0);
        add_row(nect_pkg::OP_LOOKUP, NAME_PFX, 8'h00, 32'h0, 1'b0,
                nect_pkg::ST_OK, 8'h00, 32'h0, 6'd0);
        add_row(nect_pkg::OP_REMOVE, NAME_ZERO, 8'h00, 32'h0, 1'b0,
                nect_pkg::ST_OK, 8'h00, 32'h0, 6'd0);
        add_row(nect_pkg::OP_LOOKUP, NAME_ZERO, 8'h00, 32'h0, 1'b0,
                nect_pkg::ST_OK, 8'h00, 32'h0, 6'd0);
        add_row(OP_UNUSED, NAME_ONES, 8'h00, 32'h0, 1'b0,
                nect_pkg::ST_OK, 8'h00, 32'h0, 6'd0);
        add_row(nect_pkg::OP_REMOVE, NAME_ONES, 8'h00, 32'h0, 1'b0,
                nect_pkg::ST_OK, 8'h00, 32'h0, 6'd0);
        add_row(nect_pkg::OP_REMOVE, NAME_ONES, 8'h00, 32'h0, 1'b0,
                nect_pkg::ST_OK, 8'h00, 32'h0, 6'd0);
        add_row(nect_pkg::OP_ADD, NAME_ZERO, 8'h3C, 32'h7FFF_FFFF, 1'b0,
                nect_pkg::ST_OK, 8'h00, 32'h0, 6'd0);
        add_row(nect_pkg::OP_LOOKUP, NAME_ZERO, 8'h00, 32'h0, 1'b0,
                nect_pkg::ST_OK, 8'h00, 32'h0, 6'd0);
        foreach (dir_rows[i])
            send_word(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);

        // Random part: fill and drain spells so the table runs full and empty
        fill_mode = 1'b0;
        mode_left = 0;
        for (int ph = 0; ph < 3; ph++) begin
            drain_results();
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (mode_left == 0) begin
                    fill_mode = !fill_mode;
                    mode_left = $urandom_range(40, 80);
                end
                mode_left--;
                roll = $urandom_range(99);
                if (fill_mode)
                    op = roll < 60 ? nect_pkg::OP_ADD : roll < 85 ? nect_pkg::OP_LOOKUP :
                         roll < 95 ? nect_pkg::OP_REMOVE : OP_UNUSED;
                else
                    op = roll < 15 ? nect_pkg::OP_ADD : roll < 45 ? nect_pkg::OP_LOOKUP :
                         roll < 95 ? nect_pkg::OP_REMOVE : OP_UNUSED;
                if ($urandom_range(99) == 0)
                    drain_results();
                sender_gap(sender_idle[ph]);
                send_word(make_req(op, pick_name(), 8'($urandom_range(255)), $urandom),
                          1'b0, none);
            end
        end

        // Let the last answers come back, then a short settle
        drain_results();
        repeat (8) @(posedge i_clk);
        if (pending_rsp.size() != 0)
            log_mismatch($sformatf("%0d results never arrived", pending_rsp.size()));

        if (err_count == 0)
            $display("named_entry_catalog_table_core test passed");
        else
            $display("named_entry_catalog_table_core test failed");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/nect_pkg.sv
rtl/nect_cell.sv
rtl/named_entry_catalog_table_core.sv
bench/tb_top.sv
